>>> hw/rtl/conv3x3_image_filter_unit_defines.svh
// assertion macros shared by the convolution filter rtl
`ifndef CONV3X3_IMAGE_FILTER_UNIT_DEFINES_SVH
`define CONV3X3_IMAGE_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTH
// property checked while reset is released
`define CV3_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("cv3 assertion failed");
// property checked on every edge, reset included
`define CV3_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("cv3 assertion failed");
`else
`define CV3_ASSERT(lbl, clk, rstn, prop)
`define CV3_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hw/rtl/cv3_pkg.sv
// shared types and constants of the 3x3 convolution filter
package cv3_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = PIX_W + 1 + COEF_W;
    localparam int ROW_W   = PROD_W + 2;
    localparam int SUM_W   = ROW_W + 2;
    localparam int FRAC_W  = 8;
    localparam int DIM_W   = 12;
    localparam int DIM_MIN = 3;
    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam int KROW_W  = 3 * COEF_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KROW_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

    // reset values
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 12'd480;
    localparam logic [KROW_W-1:0] RST_KERNEL_TOP    = 48'h0;
    localparam logic [KROW_W-1:0] RST_KERNEL_MIDDLE = 48'h0000_0100_0000;
    localparam logic [KROW_W-1:0] RST_KERNEL_BOTTOM = 48'h0;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hff;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             is_padding;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } out_item_t;

    // per-item sideband carried down the pipeline
    typedef struct packed {
        logic emit;
        logic pass;
        logic frame_end;
    } item_ctrl_t;

    // taps[line][age]: line 0 newest row (kernel bottom), age 0 newest column
    typedef logic [2:0][2:0][PIX_W-1:0] taps_t;

    // kernel rows, index 0 top
    typedef logic [2:0][KROW_W-1:0] krows_t;

endpackage

>>> hw/rtl/cv3_ram.sv
// generic simple dual-port ram with registered read
module cv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and read-first registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/cv3_window.sv
// two-line buffer and 3x3 tap window
`include "conv3x3_image_filter_unit_defines.svh"
module cv3_window #(
    parameter int MAX_WIDTH = cv3_pkg::DEF_MAX_WIDTH
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        rd_req,
    input  logic                        wr_req,
    input  logic [cv3_pkg::PIX_W-1:0]   pixel,
    input  logic [cv3_pkg::DIM_W-1:0]   width,
    output cv3_pkg::taps_t              taps
);
    import cv3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [AW-1:0]        col_reg;
    logic [AW-1:0]        col_next;
    logic [AW-1:0]        col_cur;
    logic [AW-1:0]        addr_reg;
    logic [2*PIX_W-1:0]   rd_data;
    logic [2*PIX_W-1:0]   wr_data;
    taps_t                taps_reg;

    // column counter wraps at the active row width; a narrowed row restarts at zero
    always_comb begin
        if (32'(col_reg) >= 32'(width)) begin
            col_cur = '0;
        end else begin
            col_cur = col_reg;
        end
        if (32'(col_cur) + 32'd1 >= 32'(width)) begin
            col_next = '0;
        end else begin
            col_next = col_cur + AW'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            col_reg <= '0;
        end else if (rd_req) begin
            col_reg <= col_next;
        end
    end

    // address of the request now in the input register
    always_ff @(posedge clk) begin
        if (rd_req) begin
            addr_reg <= col_cur;
        end
    end

    // each entry holds the pixels one and two rows back at that column
    assign wr_data = {pixel, rd_data[2*PIX_W-1:PIX_W]};

    cv3_ram #(
        .WIDTH(2 * PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk  (clk),
        .we   (wr_req),
        .waddr(addr_reg),
        .wdata(wr_data),
        .re   (rd_req),
        .raddr(col_cur),
        .rdata(rd_data)
    );

    // shift the three tap rows by one column
    always_ff @(posedge clk) begin
        if (wr_req) begin
            taps_reg[0] <= {taps_reg[0][1], taps_reg[0][0], pixel};
            taps_reg[1] <= {taps_reg[1][1], taps_reg[1][0], rd_data[2*PIX_W-1:PIX_W]};
            taps_reg[2] <= {taps_reg[2][1], taps_reg[2][0], rd_data[PIX_W-1:0]};
        end
    end

    assign taps = taps_reg;

    `CV3_ASSERT(a_col_range, clk, rstn, 32'(col_reg) < MAX_WIDTH)

endmodule

>>> hw/rtl/cv3_mac.sv
// kernel multiply, row sums and saturation
module cv3_mac (
    input  logic                      clk,
    input  logic                      rstn,
    input  logic                      en,
    input  logic                      in_valid,
    input  cv3_pkg::item_ctrl_t       in_ctrl,
    input  cv3_pkg::taps_t            taps,
    input  cv3_pkg::krows_t           krows,
    output logic                      out_valid,
    output logic [cv3_pkg::PIX_W-1:0] out_pixel,
    output logic                      out_frame_end
);
    import cv3_pkg::*;

    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic                     a_valid_reg;
    item_ctrl_t               a_ctrl_reg;
    logic [PIX_W-1:0]         a_center_reg;

    logic signed [ROW_W-1:0]  row_next [3];
    logic signed [ROW_W-1:0]  row_reg  [3];
    logic                     b_valid_reg;
    item_ctrl_t               b_ctrl_reg;
    logic [PIX_W-1:0]         b_center_reg;

    logic signed [SUM_W-1:0]  sum;
    logic [PIX_W-1:0]         sat_pixel;

    // nine products: kernel row k uses tap line 2-k, coefficient c uses age 2-c
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[k][c] = $signed({1'b0, taps[2-k][2-c]})
                                * $signed(krows[k][COEF_W*c +: COEF_W]);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg     <= prod_next;
            a_ctrl_reg   <= in_ctrl;
            a_center_reg <= taps[1][1];
        end
    end

    // one sum per kernel row
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            row_next[k] = ROW_W'(prod_reg[k][0]) + ROW_W'(prod_reg[k][1])
                        + ROW_W'(prod_reg[k][2]);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            row_reg      <= row_next;
            b_ctrl_reg   <= a_ctrl_reg;
            b_center_reg <= a_center_reg;
        end
    end

    // full sum, floor shift by eight, clamp to pixel range
    assign sum = SUM_W'(row_reg[0]) + SUM_W'(row_reg[1]) + SUM_W'(row_reg[2]);

    always_comb begin
        if (sum[SUM_W-1]) begin
            sat_pixel = '0;
        end else if (|sum[SUM_W-2:FRAC_W+PIX_W]) begin
            sat_pixel = PIX_MAX;
        end else begin
            sat_pixel = sum[FRAC_W+PIX_W-1:FRAC_W];
        end
    end

    assign out_valid     = b_valid_reg;
    assign out_pixel     = b_ctrl_reg.pass ? b_center_reg : sat_pixel;
    assign out_frame_end = b_ctrl_reg.frame_end;

endmodule

>>> hw/rtl/conv3x3_image_filter_unit.sv
// Streaming 3x3 convolution of an 8-bit grayscale frame given in raster order.
// One pixel request is taken per clock unless the path stalls, a rate set by
// the single line-buffer ram (one read and one write per pixel) feeding a
// fully pipelined multiply/add path. A result's last request passes the input
// register, sideband stage, multiply/add stages and output register before
// m_valid rises; m_valid high with m_ready low stalls the whole path. Results
// lag the input stream by w+1 pixels, so w+1 padding requests after the frame
// flush its tail. Padding requests sent before the frame is complete are taken
// and dropped. Edge columns wrap onto the neighboring rows; the first and last
// w+1 pixels pass through unchanged. Width, height and kernel rows must be
// written by the user only while the block holds no pending pixel; the block
// does not enforce this. The line buffer is not cleared after reset.
`include "conv3x3_image_filter_unit_defines.svh"
module conv3x3_image_filter_unit #(
    parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cv3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cv3_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cv3_pkg::out_item_t             m_data,
    input  logic                           cfg_we,
    input  logic [cv3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cv3_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cv3_pkg::*;

    localparam int MAXW_EFF = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int MAXH_EFF = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam int POS_W    = $clog2(MAXW_EFF * MAXH_EFF + MAXW_EFF + 1);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    krows_t             krows_reg;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [2*DIM_W-1:0] wh;
    logic [POS_W-1:0]   total;
    logic [POS_W-1:0]   lag;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               in_frame;
    logic               drop;
    logic               take;
    item_ctrl_t         ctrl_next;

    logic               en;
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;
    item_ctrl_t         s1_ctrl_reg;
    logic               s2_valid_reg;
    item_ctrl_t         s2_ctrl_reg;

    taps_t              taps;
    logic               mac_valid;
    logic [PIX_W-1:0]   mac_pixel;
    logic               mac_frame_end;

    logic               m_valid_reg;
    out_item_t          m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= RST_IMAGE_WIDTH;
            height_reg   <= RST_IMAGE_HEIGHT;
            krows_reg[0] <= RST_KERNEL_TOP;
            krows_reg[1] <= RST_KERNEL_MIDDLE;
            krows_reg[2] <= RST_KERNEL_BOTTOM;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg    <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg   <= cfg_wdata[DIM_W-1:0];
                REG_KERNEL_TOP:    krows_reg[0] <= cfg_wdata[KROW_W-1:0];
                REG_KERNEL_MIDDLE: krows_reg[1] <= cfg_wdata[KROW_W-1:0];
                REG_KERNEL_BOTTOM: krows_reg[2] <= cfg_wdata[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // geometry clamped to the legal range
    always_comb begin
        if (32'(width_reg) < DIM_MIN) begin
            w_eff = DIM_W'(DIM_MIN);
        end else if (32'(width_reg) > MAXW_EFF) begin
            w_eff = DIM_W'(MAXW_EFF);
        end else begin
            w_eff = width_reg;
        end
        if (32'(height_reg) < DIM_MIN) begin
            h_eff = DIM_W'(DIM_MIN);
        end else if (32'(height_reg) > MAXH_EFF) begin
            h_eff = DIM_W'(MAXH_EFF);
        end else begin
            h_eff = height_reg;
        end
    end

    assign wh    = w_eff * h_eff;
    assign total = POS_W'(wh);
    assign lag   = POS_W'(w_eff) + POS_W'(1);

    // stream position and per-request decisions
    assign in_frame           = pos_reg < total;
    assign drop               = in_frame && s_data.is_padding;
    assign en                 = !m_valid_reg || m_ready;
    assign s_ready            = en;
    assign take               = s_valid && en && !drop;
    assign ctrl_next.emit     = pos_reg >= lag;
    assign ctrl_next.pass     = (pos_reg < (lag << 1)) || !in_frame;
    assign ctrl_next.frame_end = pos_reg >= total + POS_W'(w_eff);
    assign pos_next           = ctrl_next.frame_end ? '0 : pos_reg + POS_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (take) begin
            pos_reg <= pos_next;
        end
    end

    // input register and sideband stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg && s1_ctrl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (take) begin
                s1_pixel_reg <= s_data.pixel_in;
                s1_ctrl_reg  <= ctrl_next;
            end
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    cv3_window #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_window (
        .clk   (aclk),
        .rstn  (aresetn),
        .rd_req(take),
        .wr_req(en && s1_valid_reg),
        .pixel (s1_pixel_reg),
        .width (w_eff),
        .taps  (taps)
    );

    cv3_mac u_mac (
        .clk          (aclk),
        .rstn         (aresetn),
        .en           (en),
        .in_valid     (s2_valid_reg),
        .in_ctrl      (s2_ctrl_reg),
        .taps         (taps),
        .krows        (krows_reg),
        .out_valid    (mac_valid),
        .out_pixel    (mac_pixel),
        .out_frame_end(mac_frame_end)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mac_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.pixel_out <= mac_pixel;
            m_data_reg.frame_end <= mac_frame_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CV3_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid_reg && !s1_valid_reg)
    `CV3_ASSERT(a_fend_passes, aclk, aresetn, s1_valid_reg && s1_ctrl_reg.frame_end |-> s1_ctrl_reg.pass)
    `CV3_ASSERT(a_emit_only, aclk, aresetn, s2_valid_reg |-> s2_ctrl_reg.emit)

endmodule
